### hdl/rpvg_pkg.sv
// Package for the regular polygon vertex generator.
// Holds the controller states, the command and status structs, and the CORDIC constants.
// Used by rpvg_ctrl, rpvg_dp and regular_polygon_vertex_generator_unit.
`default_nettype none

package rpvg_pkg;

    localparam int MAX_SIDES_DEF    = 63;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    localparam int SIDES_W = 6;
    localparam int COORD_W = 16;
    localparam int IT_W    = 5;
    localparam int XY_W    = 34;
    localparam int Z_W     = 33;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 40;

    localparam logic [XY_W-1:0] CORDIC_GAIN_Q30 = 34'd652032874;
    localparam logic [32:0]     TWO_PI_Q30      = 33'd6746518852;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ZLOAD,
        ST_ROT,
        ST_MULC,
        ST_MULS,
        ST_ROUND,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic z_load;
        logic rot_step;
        logic mul_c;
        logic mul_s;
        logic round;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic sides_ok;
        logic div_done;
        logic rot_done;
        logic out_free;
        logic last;
    } t_sts;

    function automatic logic [31:0] atan_q30(input logic [IT_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hdl/rpvg_ctrl.sv
// Controller state machine for the regular polygon vertex generator.
// Sequences division, CORDIC, scaling and output of each vertex.
// Depends on rpvg_pkg.
`default_nettype none

module rpvg_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           s_axis_tvalid,
    output logic          s_axis_tready,
    input  rpvg_pkg::t_sts i_sts,
    output rpvg_pkg::t_cmd o_cmd
);
    import rpvg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!i_sts.sides_ok) begin
                    n_state = ST_IDLE;
                end else if (i_sts.div_done) begin
                    n_state = ST_ZLOAD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_ZLOAD: begin
                o_cmd.z_load = 1'b1;
                n_state      = ST_ROT;
            end
            ST_ROT: begin
                if (i_sts.rot_done) begin
                    n_state = ST_MULC;
                end else begin
                    o_cmd.rot_step = 1'b1;
                end
            end
            ST_MULC: begin
                o_cmd.mul_c = 1'b1;
                n_state     = ST_MULS;
            end
            ST_MULS: begin
                o_cmd.mul_s = 1'b1;
                n_state     = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.last ? ST_IDLE : ST_ZLOAD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/rpvg_dp.sv
// Datapath for the regular polygon vertex generator.
// Holds the step divider, angle accumulator, CORDIC, radius scaling and output register.
// Depends on rpvg_pkg.
`default_nettype none

module rpvg_dp #(
    parameter int MAX_SIDES    = rpvg_pkg::MAX_SIDES_DEF,
    parameter int CORDIC_STEPS = rpvg_pkg::CORDIC_STEPS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [rpvg_pkg::IN_W-1:0]    i_tdata,
    input  rpvg_pkg::t_cmd               i_cmd,
    output rpvg_pkg::t_sts               o_sts,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [rpvg_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                         m_axis_tlast
);
    import rpvg_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam logic [SIDES_W-1:0] MAX_N = SIDES_W'(MAX_SIDES);
    localparam int DIV_BITS = 17;

    logic [SIDES_W-1:0]        r_n;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic [COORD_W-1:0]        r_radius;
    logic [COORD_W-1:0]        r_rot;

    logic [SIDES_W:0]   r_rem;
    logic [16:0]        r_quo;
    logic [4:0]         r_div_cnt;

    logic [16:0]        r_acc_q;
    logic [SIDES_W-1:0] r_acc_r;
    logic [SIDES_W-1:0] r_k;

    logic [1:0]                r_quad;
    logic signed [XY_W-1:0]    r_x;
    logic signed [XY_W-1:0]    r_y;
    logic signed [Z_W-1:0]     r_z;
    logic [IT_W-1:0]           r_it;

    logic signed [50:0] r_prod_c;
    logic signed [50:0] r_prod_s;
    logic signed [20:0] r_rc;
    logic signed [20:0] r_rs;

    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_vx;
    logic signed [COORD_W-1:0] r_vy;
    logic [SIDES_W-1:0]        r_idx;
    logic                      r_last;

    logic [SIDES_W-1:0]     w_sides_in;
    logic [SIDES_W:0]       w_rem_sh;
    logic                   w_qbit;
    logic [SIDES_W:0]       w_sum_r;
    logic                   w_wrap;
    logic [15:0]            w_angle;
    logic [46:0]            w_zprod;
    logic signed [XY_W-1:0] w_dx;
    logic signed [XY_W-1:0] w_dy;
    logic signed [Z_W-1:0]  w_atan;
    logic signed [XY_W-1:0] w_cos;
    logic signed [XY_W-1:0] w_sin;
    logic signed [XY_W-1:0] w_trig;
    logic signed [50:0]     w_mul;
    logic signed [50:0]     w_sum_c;
    logic signed [50:0]     w_sum_s;
    logic signed [21:0]     w_px;
    logic signed [21:0]     w_py;
    logic signed [COORD_W-1:0] w_vx;
    logic signed [COORD_W-1:0] w_vy;

    assign w_sides_in = i_tdata[SIDES_W-1:0];

    // Restoring division of one turn by the side count.
    assign w_rem_sh = {r_rem[SIDES_W-1:0], (r_div_cnt == 5'd0)};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_n});

    // Angle step: add quotient and remainder, carry when the remainder wraps.
    assign w_sum_r = {1'b0, r_acc_r} + {1'b0, r_rem[SIDES_W-1:0]};
    assign w_wrap  = (w_sum_r >= {1'b0, r_n});
    assign w_angle = r_rot + r_acc_q[15:0];
    assign w_zprod = {33'd0, w_angle[13:0]} * {14'd0, TWO_PI_Q30};

    assign w_dx   = r_y >>> r_it;
    assign w_dy   = r_x >>> r_it;
    assign w_atan = $signed({1'b0, atan_q30(r_it)});

    always_comb begin
        case (r_quad)
            2'd0: begin
                w_cos = r_x;
                w_sin = r_y;
            end
            2'd1: begin
                w_cos = -r_y;
                w_sin = r_x;
            end
            2'd2: begin
                w_cos = -r_x;
                w_sin = -r_y;
            end
            default: begin
                w_cos = r_y;
                w_sin = -r_x;
            end
        endcase
    end

    assign w_trig  = i_cmd.mul_c ? w_cos : w_sin;
    assign w_mul   = $signed({1'b0, r_radius}) * w_trig;
    assign w_sum_c = r_prod_c + (51'sd1 <<< 29);
    assign w_sum_s = r_prod_s + (51'sd1 <<< 29);

    assign w_px = {{6{r_cx[15]}}, r_cx} + {r_rc[20], r_rc};
    assign w_py = {{6{r_cy[15]}}, r_cy} + {r_rs[20], r_rs};

    always_comb begin
        if (w_px > 22'sd32767) begin
            w_vx = 16'sh7FFF;
        end else if (w_px < -22'sd32768) begin
            w_vx = -16'sh8000;
        end else begin
            w_vx = w_px[15:0];
        end
        if (w_py > 22'sd32767) begin
            w_vy = 16'sh7FFF;
        end else if (w_py < -22'sd32768) begin
            w_vy = -16'sh8000;
        end else begin
            w_vy = w_py[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n       <= (w_sides_in > MAX_N) ? MAX_N : w_sides_in;
            r_cx      <= i_tdata[21:6];
            r_cy      <= i_tdata[37:22];
            r_radius  <= i_tdata[53:38];
            r_rot     <= i_tdata[69:54];
            r_rem     <= '0;
            r_quo     <= '0;
            r_div_cnt <= '0;
            r_acc_q   <= '0;
            r_acc_r   <= '0;
            r_k       <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= w_qbit ? (w_rem_sh - {1'b0, r_n}) : w_rem_sh;
            r_quo     <= {r_quo[15:0], w_qbit};
            r_div_cnt <= r_div_cnt + 5'd1;
        end
        if (i_cmd.z_load) begin
            r_quad <= w_angle[15:14];
            r_z    <= $signed({2'b00, w_zprod[46:16]});
            r_x    <= $signed(CORDIC_GAIN_Q30);
            r_y    <= '0;
            r_it   <= '0;
        end
        if (i_cmd.rot_step) begin
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
            r_it <= r_it + 5'd1;
        end
        if (i_cmd.mul_c) begin
            r_prod_c <= w_mul;
        end
        if (i_cmd.mul_s) begin
            r_prod_s <= w_mul;
        end
        if (i_cmd.round) begin
            r_rc <= w_sum_c[50:30];
            r_rs <= w_sum_s[50:30];
        end
        if (i_cmd.emit) begin
            r_vx    <= w_vx;
            r_vy    <= w_vy;
            r_idx   <= r_k;
            r_last  <= (r_k == r_n);
            r_k     <= r_k + 6'd1;
            r_acc_r <= w_wrap ? SIDES_W'(w_sum_r - {1'b0, r_n}) : w_sum_r[SIDES_W-1:0];
            r_acc_q <= r_acc_q + r_quo + {16'd0, w_wrap};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.sides_ok = (r_n >= 6'd3);
    assign o_sts.div_done = (r_div_cnt == 5'(DIV_BITS));
    assign o_sts.rot_done = (r_it == IT_W'(STEPS));
    assign o_sts.out_free = !r_out_valid || m_axis_tready;
    assign o_sts.last     = (r_k == r_n);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_idx, r_vy, r_vx};
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

### hdl/regular_polygon_vertex_generator_unit.sv
// Top level of the regular polygon vertex generator.
// Joins the controller rpvg_ctrl and the datapath rpvg_dp; depends on rpvg_pkg.
//
// Channel   Dir  Words per polygon   Contents
// s_axis    in   1                   sides, center_x, center_y, radius, rotation
// m_axis    out  n+1, or 0 if n < 3  vertex_x, vertex_y, vertex_index; tlast on vertex n
//
// A polygon first runs the bit-serial step divider, then each vertex passes in turn through
// the shared CORDIC iteration and the shared radius multiplier.
// The unit takes no new input word while it is still working on a polygon.
// Reset clears the controller and the output valid flag.
// A stalled output holds the controller in its emit state; the last vertex may wait in
// the output register while the next input word is accepted.
`default_nettype none

module regular_polygon_vertex_generator_unit #(
    parameter int MAX_SIDES    = rpvg_pkg::MAX_SIDES_DEF,
    parameter int CORDIC_STEPS = rpvg_pkg::CORDIC_STEPS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    // sides[5:0], center_x[21:6], center_y[37:22], radius[53:38], rotation[69:54], zeros
    input  wire  [rpvg_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    // vertex_x[15:0], vertex_y[31:16], vertex_index[37:32], zeros
    output logic [rpvg_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast
);
    import rpvg_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rpvg_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    rpvg_dp #(
        .MAX_SIDES    (MAX_SIDES),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tdata       (s_axis_tdata),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### bench/regular_polygon_vertex_generator_unit_test.sv
`timescale 1ns / 100ps
// Testbench for regular_polygon_vertex_generator_unit: sends polygon words and checks every vertex
// word against a CORDIC vertex predictor kept in a small scoreboard class.
// Depends on rpvg_pkg and the unit's RTL.

module regular_polygon_vertex_generator_unit_test;

    localparam int     MAX_SIDES      = rpvg_pkg::MAX_SIDES_DEF;
    localparam int     CORDIC_STEPS   = rpvg_pkg::CORDIC_STEPS_DEF;
    localparam int     IN_W           = rpvg_pkg::IN_W;
    localparam int     OUT_W          = rpvg_pkg::OUT_W;
    localparam longint GAIN_Q30       = 64'd652032874;
    localparam longint TURN_Q30       = 64'd6746518852;
    localparam int     HOLD_CYCLES    = 1500;
    localparam int     WATCHDOG_LIMIT = 20000;
    localparam int     DRAIN_CYCLES   = 1500;
    localparam int     RANDOM_POLYGONS = 130;

    localparam longint ATAN_Q30 [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    typedef struct packed {
        logic [15:0]        rotation;
        logic [15:0]        radius;
        logic signed [15:0] center_y;
        logic signed [15:0] center_x;
        logic [5:0]         sides;
    } t_polygon;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [5:0]         index;
        logic               last;
    } t_vertex;

    class polygon_vertex_ledger;
        t_vertex vertices_due[$];
        int      errors;

        task report(string msg);
            errors++;
            $display("%0t: vertex mismatch: %s", $time, msg);
        endtask

        function void cordic_sincos(input logic [15:0] angle, output longint c, output longint s);
            longint x, y, z, dx, dy;
            longint r;
            int     steps;
            r = angle[13:0];
            z = (r * TURN_Q30) >>> 16;
            x = GAIN_Q30;
            y = 0;
            steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
            for (int i = 0; i < steps; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_Q30[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_Q30[i];
                end
            end
            case (angle[15:14])
                2'd0: begin
                    c = x;
                    s = y;
                end
                2'd1: begin
                    c = -y;
                    s = x;
                end
                2'd2: begin
                    c = -x;
                    s = -y;
                end
                default: begin
                    c = y;
                    s = -x;
                end
            endcase
        endfunction

        function logic signed [15:0] place_coord(logic signed [15:0] centre, logic [15:0] radius,
                                                 longint trig);
            longint v;
            v = longint'(centre) + ((longint'(radius) * trig + (longint'(1) << 29)) >>> 30);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function void note_polygon(t_polygon p);
            int          n;
            longint      c, s;
            logic [15:0] angle;
            t_vertex     v;
            n = p.sides;
            if (n > MAX_SIDES) n = MAX_SIDES;
            if (n < 3) return;
            for (int k = 0; k <= n; k++) begin
                angle = 16'(int'(p.rotation) + (k * 65536) / n);
                cordic_sincos(angle, c, s);
                v.x = place_coord(p.center_x, p.radius, c);
                v.y = place_coord(p.center_y, p.radius, s);
                v.index = 6'(k);
                v.last = (k == n);
                vertices_due.push_back(v);
            end
        endfunction

        task check_vertex(t_vertex got);
            t_vertex want;
            if (vertices_due.size() == 0) begin
                report($sformatf("vertex %0d arrived with no polygon pending", got.index));
                return;
            end
            want = vertices_due.pop_front();
            if (got.x !== want.x)
                report($sformatf("vertex %0d x %0d, expected %0d", want.index, got.x, want.x));
            if (got.y !== want.y)
                report($sformatf("vertex %0d y %0d, expected %0d", want.index, got.y, want.y));
            if (got.index !== want.index)
                report($sformatf("index %0d, expected %0d", got.index, want.index));
            if (got.last !== want.last)
                report($sformatf("vertex %0d tlast %b, expected %b", want.index, got.last,
                                 want.last));
        endtask
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tlast;

    polygon_vertex_ledger ledger = new;
    int      polygons_sent = 0;
    bit      steady = 1'b0;
    int      quiet_cycles = 0;
    t_vertex seen;

    regular_polygon_vertex_generator_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    task send_polygon(input logic [5:0] sides, input logic [15:0] cx, input logic [15:0] cy,
                      input logic [15:0] radius, input logic [15:0] rotation);
        t_polygon p;
        p.sides = sides;
        p.center_x = cx;
        p.center_y = cy;
        p.radius = radius;
        p.rotation = rotation;
        while (!steady && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_W - $bits(t_polygon)){1'b0}}, p};
        do @(posedge i_clk); while (!s_axis_tready);
        polygons_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.x = m_axis_tdata[15:0];
                seen.y = m_axis_tdata[31:16];
                seen.index = m_axis_tdata[37:32];
                seen.last = m_axis_tlast;
                ledger.check_vertex(seen);
            end
            if (s_axis_tvalid && s_axis_tready)
                ledger.note_polygon(t_polygon'(s_axis_tdata[$bits(t_polygon)-1:0]));
        end
    end

    // The receiver stalls once for a long stretch so the unit backs up into its input.
    initial begin
        bit held;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!held && polygons_sent >= 30) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                held = 1'b1;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 27);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("regular_polygon_vertex_generator_unit_test: errors");
                $finish;
            end
        end
    end

    initial begin
        int          shaped;
        bit          noise;
        logic [5:0]  sides;
        logic [15:0] cx, cy, radius, rotation;
        shaped = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_polygon(6'd0, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
        send_polygon(6'd1, 16'h7FFF, 16'h8000, 16'h0100, 16'h1234);
        send_polygon(6'd2, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_polygon(6'd3, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
        send_polygon(6'd4, 16'h0000, 16'h0000, 16'h4000, 16'h2000);
        send_polygon(6'd63, 16'h0000, 16'h0000, 16'h7F00, 16'h0000);
        send_polygon(6'd6, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0000);
        send_polygon(6'd6, 16'h8000, 16'h8000, 16'hFFFF, 16'h8000);
        send_polygon(6'd5, 16'h1234, 16'hEDCC, 16'h0000, 16'h1111);
        send_polygon(6'd8, 16'h0000, 16'h0000, 16'h1000, 16'hFFFF);
        send_polygon(6'd4, 16'h0000, 16'h0000, 16'h1000, 16'h4000);
        send_polygon(6'd4, 16'h0000, 16'h0000, 16'h1000, 16'hC000);
        send_polygon(6'd7, 16'hFFFF, 16'h0001, 16'h0001, 16'h3FFF);
        send_polygon(6'd32, 16'h8000, 16'h7FFF, 16'h8000, 16'hBFFF);
        send_polygon(6'd3, 16'h0000, 16'h0000, 16'hFFFF, 16'h5555);
        send_polygon(6'd63, 16'hC000, 16'h4000, 16'hFFFF, 16'hA5A5);

        while (shaped < RANDOM_POLYGONS) begin
            noise = ($urandom_range(99) < 10);
            if (noise)
                sides = 6'($urandom_range(2));
            else if ($urandom_range(99) < 70)
                sides = 6'($urandom_range(12, 3));
            else
                sides = 6'($urandom_range(63, 13));
            if ($urandom_range(1)) begin
                cx = 16'($urandom);
                cy = 16'($urandom);
            end else begin
                cx = 16'($urandom_range(16'h3FFF)) - 16'h2000;
                cy = 16'($urandom_range(16'h3FFF)) - 16'h2000;
            end
            radius = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(16'h3FFF));
            rotation = 16'($urandom);
            steady = (shaped >= 70 && shaped < 110);
            send_polygon(sides, cx, cy, radius, rotation);
            if (!noise) shaped++;
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (ledger.vertices_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0)
            $display("regular_polygon_vertex_generator_unit_test: clean");
        else
            $display("regular_polygon_vertex_generator_unit_test: errors");
        $finish;
    end

endmodule

### filelist.f
hdl/rpvg_pkg.sv
hdl/rpvg_ctrl.sv
hdl/rpvg_dp.sv
hdl/regular_polygon_vertex_generator_unit.sv
bench/regular_polygon_vertex_generator_unit_test.sv
